[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion shorthands, sampled on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock edge out of reset
`define AST_HOLDS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define AST_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define AST_HOLDS(lbl, cond)
`define AST_IMPL(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/mad_pkg.sv]
// ----------------------------------------------------------------------------
// mad_pkg
// shared types and constants of the moving average filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mad_pkg;

	// configuration register file
	localparam int  WIN_BITS      = 7;
	localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd8;
	localparam int  APB_ADDR_BITS = 3;
	localparam int  APB_DATA_BITS = 32;

	// register index, taken from paddr above the byte offset
	localparam logic REG_IDX_WINDOW = 1'b0;

	// divider status towards the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[rtl/mad_ring.sv]
// ----------------------------------------------------------------------------
// mad_ring
// sample history memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mad_ring #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 24,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/mad_div.sv]
// ----------------------------------------------------------------------------
// mad_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mad_div
	import mad_pkg::*;
#(
	parameter int NW = 30,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output div_stat_t     stat,
	output logic [NW-1:0] quotient
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   quo_q;
	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   div_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;

	logic [DW:0]   shifted;
	logic [DW+1:0] trial;
	logic          fits;

	// bring down the next dividend bit and try the subtraction
	assign shifted = {rem_q, quo_q[NW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, div_q};
	assign fits    = ~trial[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], fits};
			rem_q <= fits ? trial[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

[rtl/moving_average_filter_top.sv]
// ----------------------------------------------------------------------------
// moving_average_filter_top
// simple moving average over a configurable window of signed samples
// ----------------------------------------------------------------------------
// A sample request is taken on sample_valid/sample_ready; the matching mean
// leaves on average_valid/average_ready. Each sample gives exactly one mean of
// the most recent samples, up to the window length; while the window is still
// filling, the samples seen so far are averaged.
// One sample is processed at a time: sample_ready is low from acceptance
// until the result is loaded into the output register. After acceptance a
// sample passes the update, start, wait and finish states before
// average_valid; in the wait state the divider forms the quotient of the
// running sum one bit per cycle, and the next request is taken once the
// finish state has loaded the output register and returned to idle.
// The next sample may be taken while a finished mean still waits in the
// output register; if the receiver stalls, the following result waits in
// the sequencer until the output register frees.
// The window register sits on the APB port at address 0; writing it clears
// the history. Reset sets the window to 8 and empties the history; the ring
// memory needs no clearing pass since only entries written since the last
// clear are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module moving_average_filter_top
	import mad_pkg::*;
#(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [APB_ADDR_BITS-1:0]      paddr,
	input  logic [APB_DATA_BITS-1:0]      pwdata,
	output logic [APB_DATA_BITS-1:0]      prdata,
	output logic                          pready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          average_valid,
	input  logic                          average_ready
);

	localparam int AW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW       = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_START,
		ST_WAIT,
		ST_FIN
	} state_t;

	state_t                       state_q;
	logic [WIN_BITS-1:0]          window_q;
	logic [AW-1:0]                slot_q;
	logic [CW-1:0]                fill_q;
	logic signed [SUM_BITS-1:0]   sum_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                         evict_q;
	logic                         neg_q;
	logic signed [SAMPLE_BITS-1:0] avg_q;
	logic                         avg_valid_q;

	logic [CW-1:0]          win_eff;
	logic [AW-1:0]          old_slot;
	logic [AW-1:0]          next_slot;
	logic                   accept;
	logic                   cfg_wr;
	logic                   div_start;
	logic                   out_load;
	logic [SUM_BITS-1:0]    sum_mag;
	logic [SUM_BITS-1:0]    quo;
	logic [SUM_BITS-1:0]    quo_signed;
	logic [SAMPLE_BITS-1:0] ring_rdata;
	logic signed [SUM_BITS-1:0] old_term;
	div_stat_t              div_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite
		& (paddr[APB_ADDR_BITS-1:2] == REG_IDX_WINDOW);
	assign prdata = (paddr[APB_ADDR_BITS-1:2] == REG_IDX_WINDOW)
		? {{(APB_DATA_BITS-WIN_BITS){1'b0}}, window_q} : '0;

	// window of zero acts as one, above the ring depth it saturates
	always_comb begin
		if (window_q == '0) begin
			win_eff = CW'(1);
		end else if (32'(window_q) > 32'(MAX_WINDOW)) begin
			win_eff = CW'(MAX_WINDOW);
		end else begin
			win_eff = CW'(window_q);
		end
	end

	// oldest retained slot, wrapped around the ring
	always_comb begin
		int diff;
		diff = int'(slot_q) - int'(win_eff);
		if (diff < 0) begin
			diff = diff + MAX_WINDOW;
		end
		old_slot = diff[AW-1:0];
	end

	assign next_slot = (32'(slot_q) == 32'(MAX_WINDOW - 1)) ? '0 : slot_q + AW'(1);

	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign div_start    = (state_q == ST_START);
	assign out_load     = (state_q == ST_FIN) && (!avg_valid_q || average_ready);
	assign sum_mag      = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
	assign quo_signed   = neg_q ? (~quo + SUM_BITS'(1)) : quo;
	assign old_term     = evict_q ? SUM_BITS'($signed(ring_rdata)) : '0;

	mad_ring #(
		.DEPTH (MAX_WINDOW),
		.WIDTH (SAMPLE_BITS),
		.AW    (AW)
	) u_ring (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (slot_q),
		.wdata (sample_q),
		.re    (accept),
		.raddr (old_slot),
		.rdata (ring_rdata)
	);

	mad_div #(
		.NW (SUM_BITS),
		.DW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_mag),
		.divisor  (fill_q),
		.stat     (div_stat),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= WIN_RESET;
			slot_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			evict_q     <= 1'b0;
			neg_q       <= 1'b0;
			avg_valid_q <= 1'b0;
		end else begin
			// a new mean replaces the one leaving in the same cycle
			if (out_load) begin
				avg_valid_q <= 1'b1;
			end else if (average_valid && average_ready) begin
				avg_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				window_q <= pwdata[WIN_BITS-1:0];
				slot_q   <= '0;
				fill_q   <= '0;
				sum_q    <= '0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						evict_q <= (fill_q >= win_eff);
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					// oldest sample leaves as the new one enters
					sum_q   <= sum_q - old_term + SUM_BITS'(sample_q);
					fill_q  <= evict_q ? win_eff : fill_q + CW'(1);
					slot_q  <= next_slot;
					state_q <= ST_START;
				end
				ST_START: begin
					neg_q   <= sum_q[SUM_BITS-1];
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
		end
		if (out_load) begin
			avg_q <= $signed(quo_signed[SAMPLE_BITS-1:0]);
		end
	end

	assign average       = avg_q;
	assign average_valid = avg_valid_q;

	`AST_HOLDS(a_fill_in_window, fill_q <= win_eff)
	`AST_IMPL(a_done_while_waiting, div_stat.done, state_q == ST_WAIT)
	`AST_NEXT(a_busy_after_request, accept, !sample_ready)

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the moving average filter: a directed table of
// sample requests and window writes, then randomised phases under three
// idling patterns, each mean checked against its row or a local sum predictor
// ----------------------------------------------------------------------------

module tb;
	import mad_pkg::*;

	localparam int MAX_WIN = 64;
	localparam int SBITS   = 24;
	localparam logic [APB_ADDR_BITS-1:0] WIN_ADDR = {REG_IDX_WINDOW, 2'b00};
	localparam int SMAX = (1 << (SBITS - 1)) - 1;
	localparam int SMIN = -(1 << (SBITS - 1));
	localparam int PEND_DEPTH = 16;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_BITS-1:0] paddr = '0;
	logic [APB_DATA_BITS-1:0] pwdata = '0;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;
	logic signed [SBITS-1:0] sample = '0;
	logic sample_valid = 1'b0;
	logic sample_ready;
	logic signed [SBITS-1:0] average;
	logic average_valid;
	logic average_ready = 1'b0;

	moving_average_filter_top #(
		.MAX_WINDOW(MAX_WIN),
		.SAMPLE_BITS(SBITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample(sample),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.average(average),
		.average_valid(average_valid),
		.average_ready(average_ready)
	);

	always #2 clk = ~clk;

	// predictor state
	logic signed [SBITS-1:0] hist_ring [MAX_WIN];
	int unsigned hist_slot;
	int unsigned hist_count;
	longint hist_sum;
	logic [WIN_BITS-1:0] win_reg;

	// expected means in request order, written by the sender, read by the checker
	logic signed [SBITS-1:0] pending_means [PEND_DEPTH];
	int pend_wr = 0;
	int pend_rd = 0;
	logic signed [SBITS-1:0] want_mean;

	int errors = 0;
	int n_samples = 0;
	int n_means = 0;
	int n_windows = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic logic signed [SBITS-1:0] next_mean(input logic signed [SBITS-1:0] s);
		int unsigned w;
		int unsigned oldest;
		w = (win_reg == 0) ? 1 : ((win_reg > MAX_WIN) ? MAX_WIN : win_reg);
		if (hist_count > w)
			hist_count = w;
		// full window: oldest sample leaves before the new one enters
		if (hist_count == w) begin
			oldest = (hist_slot + MAX_WIN - w) % MAX_WIN;
			hist_sum -= hist_ring[oldest];
			hist_count--;
		end
		hist_ring[hist_slot] = s;
		hist_sum += s;
		hist_count++;
		hist_slot = (hist_slot + 1) % MAX_WIN;
		return SBITS'(hist_sum / longint'(hist_count));
	endfunction

	function automatic logic signed [SBITS-1:0] rand_sample();
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 2)
			return SBITS'(SMAX);
		else if (pick < 4)
			return SBITS'(SMIN);
		else if (pick < 8)
			return SBITS'($signed($urandom_range(0, 1024)) - 512);
		else
			return SBITS'($urandom);
	endfunction

	// drain: wait until every mean is back and the filter has settled
	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pend_wr != pend_rd)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input logic [APB_DATA_BITS-1:0] value);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIN_ADDR;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		win_reg = value[WIN_BITS-1:0];
		hist_slot = 0;
		hist_count = 0;
		hist_sum = 0;
		n_windows++;
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== APB_DATA_BITS'(win_reg)) begin
			errors++;
			$error("window_length: expected %0d, actual %0d", win_reg, prdata);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_sample(input logic signed [SBITS-1:0] s, input bit typed,
			input logic signed [SBITS-1:0] typed_mean);
		logic signed [SBITS-1:0] m;
		@(negedge clk);
		// sender idles cycle by cycle before offering the next request
		while ($urandom_range(0, 99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample <= s;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
		m = next_mean(s);
		pending_means[pend_wr % PEND_DEPTH] = typed ? typed_mean : m;
		pend_wr++;
		n_samples++;
	endtask

	always @(negedge clk)
		average_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && average_valid && average_ready) begin
			n_means++;
			if (pend_wr == pend_rd) begin
				errors++;
				$error("average: expected none, actual %0d", average);
			end else begin
				want_mean = pending_means[pend_rd % PEND_DEPTH];
				pend_rd++;
				if (average !== want_mean) begin
					errors++;
					$error("average: expected %0d, actual %0d", want_mean, average);
				end
			end
		end
	end

	typedef struct packed {
		bit is_win;
		bit typed;
		int value;
		int mean;
	} step_t;

	localparam int N_DIRECTED = 22;
	step_t directed [N_DIRECTED] = '{
		'{1'b0, 1'b1, SMAX, SMAX},     // first mean is the first sample
		'{1'b0, 1'b0, SMIN, 0},
		'{1'b0, 1'b0, 0, 0},
		'{1'b0, 1'b0, 1, 0},
		'{1'b0, 1'b0, -1, 0},
		'{1'b1, 1'b0, 0, 0},           // zero window acts as one
		'{1'b0, 1'b1, SMIN, SMIN},
		'{1'b0, 1'b1, SMAX, SMAX},
		'{1'b0, 1'b1, -1, -1},
		'{1'b1, 1'b0, 2, 0},
		'{1'b0, 1'b1, 5, 5},
		'{1'b0, 1'b1, 7, 6},
		'{1'b0, 1'b1, 9, 8},
		'{1'b0, 1'b1, -3, 3},
		'{1'b0, 1'b1, -4, -3},         // truncation toward zero
		'{1'b1, 1'b0, 127, 0},         // saturates at the ring depth
		'{1'b0, 1'b1, SMAX, SMAX},
		'{1'b0, 1'b1, SMAX, SMAX},
		'{1'b0, 1'b0, SMIN, 0},
		'{1'b1, 1'b0, 65, 0},
		'{1'b0, 1'b1, SMIN, SMIN},
		'{1'b0, 1'b0, SMIN + 1, 0}
	};

	int phase_win [12] = '{0, 127, 5, -1, 64, 1, 3, -1, 2, 65, -1, 8};
	int phase_len [12] = '{30, 100, 40, 30, 90, 30, 50, 30, 40, 80, 40, 40};

	initial begin
		win_reg = WIN_RESET;
		hist_slot = 0;
		hist_count = 0;
		hist_sum = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 47;
		foreach (directed[i]) begin
			if (directed[i].is_win)
				set_window(directed[i].value);
			else
				send_sample(SBITS'(directed[i].value), directed[i].typed,
					SBITS'(directed[i].mean));
		end

		for (int p = 0; p < 12; p++) begin
			case (p / 4)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 47;
				end
				1: begin
					send_idle_pct = 47;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_window((phase_win[p] < 0) ? $urandom_range(0, 127) : phase_win[p]);
			for (int k = 0; k < phase_len[p]; k++)
				send_sample(rand_sample(), 1'b0, '0);
		end

		wait_idle();
		repeat (40) @(posedge clk);
		$display("%0d sample requests over %0d window settings, %0d means compared",
			n_samples, n_windows, n_means);
		$display("idling: sender and receiver stalls in both mixes, then back-to-back");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4ms;
		$display("timeout with %0d means outstanding", pend_wr - pend_rd);
		$display("CHECK FAILED");
		$finish;
	end

endmodule
